// ===== src/hdsf_pkg.sv =====
// shared types and codes for the half-duplex serial fifo
`timescale 1ns / 1ps

package hdsf_pkg;

	localparam int unsigned BYTE_W = 8;

	typedef enum logic [1:0] {
		CMD_HOST_PUT  = 2'd0,
		CMD_HOST_GET  = 2'd1,
		CMD_LINE_RX   = 2'd2,
		CMD_TX_READY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RX_EMPTY = 2'd1,
		ST_TX_FULL  = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	// outcome of one transaction, minus the byte that comes back from a ring
	typedef struct packed {
		logic    rd_rx;
		logic    rd_tx;
		status_t status;
		logic    line_send;
		logic    drive_enable;
		logic    rx_available;
		logic    tx_drained;
	} hdsf_res_t;

endpackage

// ===== src/hdsf_ring_mem.sv =====
// one ring store: single write port, single registered read port
`timescale 1ns / 1ps

module hdsf_ring_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [hdsf_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [hdsf_pkg::BYTE_W-1:0] rdata
);
	import hdsf_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/hdsf_ctrl.sv =====
// ring pointers, drive state and per-command decode
`timescale 1ns / 1ps

module hdsf_ctrl #(
	parameter int unsigned RING_DEPTH = 64,
	parameter int unsigned PTR_W      = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  hdsf_pkg::cmd_t      cmd,
	output logic                rx_we,
	output logic [PTR_W-1:0]    rx_waddr,
	output logic                rx_re,
	output logic [PTR_W-1:0]    rx_raddr,
	output logic                tx_we,
	output logic [PTR_W-1:0]    tx_waddr,
	output logic                tx_re,
	output logic [PTR_W-1:0]    tx_raddr,
	output hdsf_pkg::hdsf_res_t res
);
	import hdsf_pkg::*;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [PTR_W-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d;
	logic [PTR_W-1:0] rx_head_nx, rx_tail_nx, tx_head_nx, tx_tail_nx;
	logic             driving_q, driving_d;
	logic             rx_empty, tx_empty, tx_full;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	assign rx_head_nx = ring_next(rx_head_q);
	assign rx_tail_nx = ring_next(rx_tail_q);
	assign tx_head_nx = ring_next(tx_head_q);
	assign tx_tail_nx = ring_next(tx_tail_q);

	assign rx_empty = (rx_head_q == rx_tail_q);
	assign tx_empty = (tx_head_q == tx_tail_q);
	assign tx_full  = (tx_head_nx == tx_tail_q);

	always_comb begin
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		driving_d = driving_q;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		tx_we     = 1'b0;
		tx_re     = 1'b0;
		res.rd_rx     = 1'b0;
		res.rd_tx     = 1'b0;
		res.status    = ST_OK;
		res.line_send = 1'b0;
		unique case (cmd)
			CMD_HOST_PUT: begin
				if (tx_full) begin
					res.status = ST_TX_FULL;
				end else begin
					tx_we     = accept;
					tx_head_d = tx_head_nx;
				end
			end
			CMD_HOST_GET: begin
				if (rx_empty) begin
					res.status = ST_RX_EMPTY;
				end else begin
					rx_re     = accept;
					res.rd_rx = 1'b1;
					rx_tail_d = rx_tail_nx;
				end
			end
			CMD_LINE_RX: begin
				// no overflow check: a full ring wraps onto its unread bytes
				rx_we     = accept;
				rx_head_d = rx_head_nx;
			end
			CMD_TX_READY: begin
				if (!tx_empty) begin
					tx_re         = accept;
					res.rd_tx     = 1'b1;
					res.line_send = 1'b1;
					tx_tail_d     = tx_tail_nx;
					driving_d     = 1'b1;
				end else begin
					driving_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res.drive_enable = driving_d;
		res.rx_available = (rx_head_d != rx_tail_d);
		res.tx_drained   = (tx_head_d == tx_tail_d);
	end

	assign rx_waddr = rx_head_q;
	assign rx_raddr = rx_tail_q;
	assign tx_waddr = tx_head_nx;
	assign tx_raddr = tx_tail_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			driving_q <= 1'b0;
		end else if (accept) begin
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			driving_q <= driving_d;
		end
	end

endmodule

// ===== src/half_duplex_serial_fifo.sv =====
// top level: half-duplex serial transmit and receive rings
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                                | tuser
// s_      | in  | data_in[7:0]                                      | command[1:0]
// m_      | out | data_out[7:0], drive_enable, rx_available,        | status[1:0],
//         |     | tx_drained, zero pad [15:11]                      | line_send
//
// one transaction per cycle sustained while the output is not stalled; a result passes through
// stage one (the registered read port of the ring stores) and then the output register
// a read of the stores is issued on acceptance and lands in stage one
// reset clears pointers, drive state and valids; the stores are not cleared
// a stalled output holds stage one, which in turn holds s_tready low

module half_duplex_serial_fifo #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_in[7:0]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // data_out[7:0], drive_enable, rx_available, tx_drained, pad
	output logic [2:0]  m_tuser    // status[1:0], line_send
);
	import hdsf_pkg::*;

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);

	logic              accept;
	cmd_t              cmd;
	hdsf_res_t         res;
	logic              rx_we, rx_re, tx_we, tx_re;
	logic [PTR_W-1:0]  rx_waddr, rx_raddr, tx_waddr, tx_raddr;
	logic [BYTE_W-1:0] rx_rdata, tx_rdata;

	// stage one: memory read in flight, decode result alongside
	logic              valid_s1;
	hdsf_res_t         res_s1;
	logic              adv_s1;
	logic [BYTE_W-1:0] byte_s1;

	// output register
	logic              out_valid_q;
	hdsf_res_t         out_res_q;
	logic [BYTE_W-1:0] out_byte_q;

	assign cmd    = cmd_t'(s_tuser);
	assign adv_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept = s_tvalid && s_tready;

	hdsf_ctrl #(
		.RING_DEPTH (RING_DEPTH),
		.PTR_W      (PTR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.rx_we    (rx_we),
		.rx_waddr (rx_waddr),
		.rx_re    (rx_re),
		.rx_raddr (rx_raddr),
		.tx_we    (tx_we),
		.tx_waddr (tx_waddr),
		.tx_re    (tx_re),
		.tx_raddr (tx_raddr),
		.res      (res)
	);

	// receive store: line bytes in, host reads out
	hdsf_ring_mem #(
		.DEPTH (RING_DEPTH),
		.AW    (PTR_W)
	) u_rx_mem (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (s_tdata),
		.re    (rx_re),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	// transmit store: host bytes in, transmitter reads out
	hdsf_ring_mem #(
		.DEPTH (RING_DEPTH),
		.AW    (PTR_W)
	) u_tx_mem (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (s_tdata),
		.re    (tx_re),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	// the read data register holds while stage one is stalled, since reads fire on accept only
	always_comb begin
		priority if (res_s1.rd_rx) begin
			byte_s1 = rx_rdata;
		end else if (res_s1.rd_tx) begin
			byte_s1 = tx_rdata;
		end else begin
			byte_s1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (adv_s1) begin
			out_res_q  <= res_s1;
			out_byte_q <= byte_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_res_q.tx_drained, out_res_q.rx_available,
	                   out_res_q.drive_enable, out_byte_q};
	assign m_tuser  = {out_res_q.line_send, out_res_q.status};

endmodule

// ===== dv/tb_half_duplex_serial_fifo.sv =====
// self-checking testbench for the half-duplex serial fifo, driven and checked as streams
`timescale 1ns / 1ps

module tb_half_duplex_serial_fifo;
	import hdsf_pkg::*;

	localparam int unsigned RING_DEPTH = 64;
	localparam int unsigned IDLE_LIMIT = 1000;   // cycles without any handshake
	localparam int unsigned MAX_REPORTS = 10;

	// one event offered on the slave side
	typedef struct {
		cmd_t       cmd;
		logic [7:0] octet;
		bit         wait_idle;   // hold this event back until every reply is in
	} ring_event_t;

	// one reply as it leaves the master side
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       line_send;
		logic       drive_en;
		logic       rx_avail;
		logic       tx_empty;
	} line_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;      // data_in[7:0]
	logic [1:0]  s_tuser = CMD_HOST_PUT;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // data_out[7:0], drive_enable, rx_available, tx_drained, pad
	logic [2:0]  m_tuser;           // status[1:0], line_send

	ring_event_t pending_events[$];
	line_reply_t expected_replies[$];

	// shadow copy of both rings and the driver direction
	logic [7:0]  rx_ring [RING_DEPTH];
	logic [7:0]  tx_ring [RING_DEPTH];
	int unsigned rx_wr = 0, rx_rd = 0, tx_wr = 0, tx_rd = 0;
	logic        line_driven = 1'b0;

	int unsigned sent_cnt = 0, got_cnt = 0, miscompares = 0;
	int unsigned full_puts = 0, empty_gets = 0, rx_overflows = 0, line_bytes = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	half_duplex_serial_fifo #(.RING_DEPTH(RING_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// works out the reply to one accepted event and advances the shadow rings
	function automatic void predict_ring_event(cmd_t cmd, logic [7:0] octet);
		line_reply_t r;
		r = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_HOST_PUT: begin
				if ((tx_wr + 1) % RING_DEPTH == tx_rd) begin
					r.status = ST_TX_FULL;
					full_puts++;
				end else begin
					tx_wr = (tx_wr + 1) % RING_DEPTH;
					tx_ring[tx_wr] = octet;
				end
			end
			CMD_HOST_GET: begin
				if (rx_wr == rx_rd) begin
					r.status = ST_RX_EMPTY;
					empty_gets++;
				end else begin
					r.data = rx_ring[rx_rd];
					rx_rd = (rx_rd + 1) % RING_DEPTH;
				end
			end
			CMD_LINE_RX: begin
				// no overflow guard: catching up with the read side empties the ring
				rx_ring[rx_wr] = octet;
				rx_wr = (rx_wr + 1) % RING_DEPTH;
				if (rx_wr == rx_rd)
					rx_overflows++;
			end
			default: begin
				if (tx_wr != tx_rd) begin
					tx_rd = (tx_rd + 1) % RING_DEPTH;
					r.data = tx_ring[tx_rd];
					r.line_send = 1'b1;
					line_driven = 1'b1;
					line_bytes++;
				end else begin
					line_driven = 1'b0;
				end
			end
		endcase
		r.drive_en = line_driven;
		r.rx_avail = (rx_wr != rx_rd);
		r.tx_empty = (tx_wr == tx_rd);
		expected_replies.push_back(r);
	endfunction

	function automatic string describe(line_reply_t r);
		return $sformatf("data %02h status %0d send %b drive %b rx_avail %b tx_empty %b",
			r.data, r.status, r.line_send, r.drive_en, r.rx_avail, r.tx_empty);
	endfunction

	task automatic plan_event(cmd_t cmd, logic [7:0] octet, bit wait_idle);
		ring_event_t ev;
		ev.cmd = cmd;
		ev.octet = octet;
		ev.wait_idle = wait_idle;
		pending_events.push_back(ev);
	endtask

	// sender: holds each transaction until accepted, idles at random otherwise
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic        offer;
		bit          quiet;
		ring_event_t ev;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= CMD_HOST_PUT;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_ring_event(cmd_t'(s_tuser), s_tdata);
				sent_cnt++;
				offer = 1'b0;
			end
			// no gaps during the receiver hold-off or the quiet window
			quiet = (hold_left != 0) || (sent_cnt >= 350 && sent_cnt < 450);
			if (!offer && pending_events.size() != 0 &&
			    !(pending_events[0].wait_idle && expected_replies.size() != 0) &&
			    (quiet || $urandom_range(0, 99) >= 25)) begin
				ev = pending_events.pop_front();
				s_tdata <= ev.octet;
				s_tuser <= ev.cmd;
				offer = 1'b1;
			end
			s_tvalid <= offer;
		end
	end

	// receiver: checks each result transaction, stalls at random and once for a long stretch
	always @(posedge clk or negedge arst_n) begin : sink_proc
		line_reply_t got, want;
		logic        take;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.data      = m_tdata[7:0];
				got.drive_en  = m_tdata[8];
				got.rx_avail  = m_tdata[9];
				got.tx_empty  = m_tdata[10];
				got.status    = m_tuser[1:0];
				got.line_send = m_tuser[2];
				got_cnt++;
				if (expected_replies.size() == 0) begin
					miscompares++;
					if (miscompares <= MAX_REPORTS)
						$display("result %0d with nothing expected: %s", got_cnt, describe(got));
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						miscompares++;
						if (miscompares <= MAX_REPORTS)
							$display("result %0d mismatch\n  expected %s\n  actual   %s",
								got_cnt, describe(want), describe(got));
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else if (!hold_done && got_cnt >= 200) begin
				// long back-pressure so the pipeline fills and s_tready drops
				hold_done = 1'b1;
				hold_left = 80;
				take = 1'b0;
			end else begin
				take = (got_cnt >= 350 && got_cnt < 450) || ($urandom_range(0, 99) >= 25);
			end
			m_tready <= take;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin : watchdog_proc
		int unsigned stuck;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", stuck);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus_proc
		int unsigned rnd, kind, len;
		cmd_t        c;

		// directed: empty edges, every command, extreme bytes
		plan_event(CMD_HOST_GET, 8'h00, 1'b0);        // get on empty receive ring
		plan_event(CMD_TX_READY, 8'hff, 1'b0);        // transmitter ready, nothing queued
		plan_event(CMD_HOST_PUT, 8'h00, 1'b0);
		plan_event(CMD_HOST_PUT, 8'hff, 1'b0);
		plan_event(CMD_HOST_PUT, 8'ha5, 1'b0);
		plan_event(CMD_TX_READY, 8'h00, 1'b0);
		plan_event(CMD_TX_READY, 8'h00, 1'b0);
		plan_event(CMD_TX_READY, 8'h00, 1'b0);
		plan_event(CMD_TX_READY, 8'h00, 1'b0);        // queue drained, driver released
		plan_event(CMD_LINE_RX, 8'h00, 1'b0);
		plan_event(CMD_LINE_RX, 8'hff, 1'b0);
		plan_event(CMD_LINE_RX, 8'h5a, 1'b0);
		plan_event(CMD_HOST_GET, 8'hff, 1'b0);
		plan_event(CMD_HOST_GET, 8'h00, 1'b0);
		plan_event(CMD_HOST_GET, 8'h00, 1'b0);
		plan_event(CMD_HOST_GET, 8'h00, 1'b0);
		plan_event(CMD_HOST_PUT, 8'h3c, 1'b1);        // sender waits for all replies first

		// random: the first four rounds fill the transmit ring up to or past full, drain it, may
		// overrun the receive ring and drain it; later rounds mix bursts and noise
		rnd = 0;
		while (pending_events.size() < 550) begin
			kind = (rnd < 4) ? rnd : $urandom_range(0, 9);
			len  = (rnd < 4) ? $urandom_range(62, 70) :
			       (kind < 4) ? $urandom_range(10, 70) : $urandom_range(4, 20);
			for (int i = 0; i < len; i++) begin
				case (kind)
					0:       c = CMD_HOST_PUT;
					1:       c = CMD_TX_READY;
					2:       c = CMD_LINE_RX;
					3:       c = CMD_HOST_GET;
					default: c = cmd_t'($urandom_range(0, 3));
				endcase
				plan_event(c, 8'($urandom_range(0, 255)),
					(i == 0) && ($urandom_range(0, 7) == 0));
			end
			rnd++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d transactions over all four commands, %0d bytes sent on the line",
			sent_cnt, line_bytes);
		$display("puts refused on full ring %0d, gets on empty ring %0d, receive overruns %0d",
			full_puts, empty_gets, rx_overflows);
		if (miscompares == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatching results", miscompares);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== half_duplex_serial_fifo.f =====
src/hdsf_pkg.sv
src/hdsf_ring_mem.sv
src/hdsf_ctrl.sv
src/half_duplex_serial_fifo.sv
dv/tb_half_duplex_serial_fifo.sv
